[src/cell_average_ascii_mapper_top_defines.svh]
// assertion helpers for the files that check their own logic
// both expect clk and rst_n in the scope where they are used
`ifndef CELL_AVERAGE_ASCII_MAPPER_TOP_DEFINES_SVH
`define CELL_AVERAGE_ASCII_MAPPER_TOP_DEFINES_SVH

// same-cycle implication
`define CAAM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/caam_pkg.sv]
package caam_pkg;

    localparam int MAX_GRID_COLS = 256;
    localparam int MAX_FRAME_DIM = 4096;
    localparam int GRID_ROWS_LIMIT = 256;

    localparam int CFG_W = 13;
    localparam int GRID_W = 9;
    localparam int CFG_IDX_W = 2;
    localparam int DIM_W = $clog2(MAX_FRAME_DIM);
    localparam int CELL_W = DIM_W + 1;
    localparam int N_W = 2 * DIM_W + 1;
    localparam int COL_W = $clog2(MAX_GRID_COLS);
    localparam int ROW_W = 8;
    localparam int SUM_W = 32;
    localparam int GRAY_W = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd3;

    localparam int RESET_FRAME_WIDTH = 640;
    localparam int RESET_FRAME_HEIGHT = 480;
    localparam int RESET_GRID_COLS = 210;
    localparam int RESET_GRID_ROWS = 52;
    localparam int RESET_CELL_W = RESET_FRAME_WIDTH / RESET_GRID_COLS;
    localparam int RESET_CELL_H = RESET_FRAME_HEIGHT / RESET_GRID_ROWS;
    localparam int RESET_CELL_N = RESET_CELL_W * RESET_CELL_H;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              first;
        logic              last;
        logic              row_end;
    } caam_item_t;

    typedef struct packed {
        logic [6:0]        char_code;
        logic [3:0]        level;
        logic [GRAY_W-1:0] cell_avg;
        logic [COL_W-1:0]  cell_col;
        logic [ROW_W-1:0]  cell_row;
        logic              row_end;
    } caam_result_t;

    // floor(avg * 10 / 255), capped at 9
    function automatic logic [3:0] caam_level(input logic [GRAY_W-1:0] avg);
        logic [11:0] scaled;
        logic [3:0]  lvl;
        scaled = 12'(avg) * 12'd10;
        lvl = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (scaled >= 12'(255 * k))
            begin
                lvl = lvl + 4'd1;
            end
        end
        return lvl;
    endfunction

    // ramp " .:-=+*#%@"
    function automatic logic [6:0] caam_char(input logic [3:0] lvl);
        logic [6:0] c;
        case (lvl)
            4'd0:    c = 7'd32;
            4'd1:    c = 7'd46;
            4'd2:    c = 7'd58;
            4'd3:    c = 7'd45;
            4'd4:    c = 7'd61;
            4'd5:    c = 7'd43;
            4'd6:    c = 7'd42;
            4'd7:    c = 7'd35;
            4'd8:    c = 7'd37;
            4'd9:    c = 7'd64;
            default: c = 7'd32;
        endcase
        return c;
    endfunction

endpackage

[src/caam_ram.sv]
module caam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        // read-first, output holds while rd_en is low
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/caam_front.sv]
module caam_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [caam_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [caam_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           push,
    input  logic [caam_pkg::GRAY_W-1:0]    gray,
    input  logic                           frame_start,
    output logic                           full,
    input  logic                           q_full,
    output logic                           q_push,
    output caam_pkg::caam_item_t           q_item,
    output logic [caam_pkg::N_W-1:0]       cell_n
);

    import caam_pkg::*;

    localparam int POS_W1 = DIM_W + 1;
    localparam int DV_CNT_W = $clog2(CELL_W);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_DIV_W = 3'd2;
    localparam logic [2:0] ST_DIV_H = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_DIV_X = 3'd5;
    localparam logic [2:0] ST_DIV_Y = 3'd6;

    logic [CFG_W-1:0]    fw_reg, fw_next, fh_reg, fh_next;
    logic [GRID_W-1:0]   gc_reg, gc_next, gr_reg, gr_next;
    logic [CELL_W-1:0]   cell_w_reg, cell_w_next, cell_h_reg, cell_h_next;
    logic [N_W-1:0]      cell_n_reg, cell_n_next;
    logic                ok_reg, ok_next;
    logic [2:0]          state_reg, state_next;
    logic [DIM_W-1:0]    x_reg, x_next, y_reg, y_next;
    logic [DIM_W-1:0]    col_reg, col_next, row_reg, row_next;
    logic [CELL_W-1:0]   lx_reg, lx_next, ly_reg, ly_next;
    logic [CELL_W-1:0]   dv_quo_reg, dv_quo_next, dv_rem_reg, dv_rem_next;
    logic [CELL_W-1:0]   dv_den_reg, dv_den_next;
    logic [DV_CNT_W-1:0] dv_cnt_reg, dv_cnt_next;

    logic                busy, accept, in_grid, geom_ok;
    logic [DIM_W-1:0]    cur_x, cur_y, cur_col, cur_row;
    logic [CELL_W-1:0]   cur_lx, cur_ly, lx_inc, ly_inc;
    logic [POS_W1-1:0]   x_inc, y_inc;
    logic                wrap_x, wrap_y;
    logic [CELL_W:0]     dv_trial;
    logic                dv_ge, dv_last;
    logic [CELL_W-1:0]   dv_quo_step, dv_rem_step;
    logic [2*CELL_W-1:0] product;

    assign busy = (state_reg != ST_IDLE);
    assign full = busy || q_full;
    assign accept = push && !full;
    assign cell_n = cell_n_reg;

    // shared restoring divider, one quotient bit a cycle
    always_comb
    begin
        dv_trial = {dv_rem_reg, dv_quo_reg[CELL_W-1]};
        dv_ge = (dv_trial >= {1'b0, dv_den_reg});
        dv_rem_step = dv_ge ? CELL_W'(dv_trial - {1'b0, dv_den_reg}) : CELL_W'(dv_trial);
        dv_quo_step = {dv_quo_reg[CELL_W-2:0], dv_ge};
        dv_last = (dv_cnt_reg == DV_CNT_W'(CELL_W - 1));
        product = cell_w_reg * cell_h_reg;
    end

    always_comb
    begin
        geom_ok = (gc_reg != '0) && (gr_reg != '0)
               && (32'(gc_reg) <= 32'(MAX_GRID_COLS))
               && (32'(gr_reg) <= 32'(GRID_ROWS_LIMIT))
               && (32'(fw_reg) <= 32'(MAX_FRAME_DIM))
               && (32'(fh_reg) <= 32'(MAX_FRAME_DIM))
               && (32'(gc_reg) <= 32'(fw_reg))
               && (32'(gr_reg) <= 32'(fh_reg));
    end

    // pixel classification
    always_comb
    begin
        cur_x   = frame_start ? '0 : x_reg;
        cur_y   = frame_start ? '0 : y_reg;
        cur_col = frame_start ? '0 : col_reg;
        cur_row = frame_start ? '0 : row_reg;
        cur_lx  = frame_start ? '0 : lx_reg;
        cur_ly  = frame_start ? '0 : ly_reg;

        in_grid = ok_reg && (32'(cur_col) < 32'(gc_reg)) && (32'(cur_row) < 32'(gr_reg));
        q_push = accept && in_grid;

        q_item.gray    = gray;
        q_item.col     = COL_W'(cur_col);
        q_item.row     = ROW_W'(cur_row);
        q_item.first   = (cur_lx == '0) && (cur_ly == '0);
        q_item.last    = (cur_lx == CELL_W'(cell_w_reg - 1'b1))
                      && (cur_ly == CELL_W'(cell_h_reg - 1'b1));
        q_item.row_end = ((32'(cur_col) + 32'd1) == 32'(gc_reg));

        x_inc = {1'b0, cur_x} + POS_W1'(1);
        y_inc = {1'b0, cur_y} + POS_W1'(1);
        lx_inc = cur_lx + CELL_W'(1);
        ly_inc = cur_ly + CELL_W'(1);
        wrap_x = (32'(x_inc) >= 32'(fw_reg)) || (32'(x_inc) >= 32'(MAX_FRAME_DIM));
        wrap_y = (32'(y_inc) >= 32'(fh_reg)) || (32'(y_inc) >= 32'(MAX_FRAME_DIM));
    end

    always_comb
    begin
        fw_next = fw_reg;
        fh_next = fh_reg;
        gc_next = gc_reg;
        gr_next = gr_reg;
        cell_w_next = cell_w_reg;
        cell_h_next = cell_h_reg;
        cell_n_next = cell_n_reg;
        ok_next = ok_reg;
        state_next = state_reg;
        x_next = x_reg;
        y_next = y_reg;
        col_next = col_reg;
        row_next = row_reg;
        lx_next = lx_reg;
        ly_next = ly_reg;
        dv_quo_next = dv_quo_step;
        dv_rem_next = dv_rem_step;
        dv_den_next = dv_den_reg;
        dv_cnt_next = dv_cnt_reg + DV_CNT_W'(1);

        if (accept)
        begin
            if (wrap_x)
            begin
                x_next = '0;
                lx_next = '0;
                col_next = '0;
                if (wrap_y)
                begin
                    y_next = '0;
                    ly_next = '0;
                    row_next = '0;
                end
                else
                begin
                    y_next = DIM_W'(y_inc);
                    if (ly_inc == cell_h_reg)
                    begin
                        ly_next = '0;
                        row_next = cur_row + DIM_W'(1);
                    end
                    else
                    begin
                        ly_next = ly_inc;
                        row_next = cur_row;
                    end
                end
            end
            else
            begin
                x_next = DIM_W'(x_inc);
                y_next = cur_y;
                ly_next = cur_ly;
                row_next = cur_row;
                if (lx_inc == cell_w_reg)
                begin
                    lx_next = '0;
                    col_next = cur_col + DIM_W'(1);
                end
                else
                begin
                    lx_next = lx_inc;
                    col_next = cur_col;
                end
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_START:
            begin
                ok_next = 1'b0;
                if (geom_ok)
                begin
                    dv_quo_next = CELL_W'(fw_reg);
                    dv_rem_next = '0;
                    dv_den_next = CELL_W'(gc_reg);
                    dv_cnt_next = '0;
                    state_next = ST_DIV_W;
                end
                else
                begin
                    cell_w_next = '0;
                    cell_h_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_W:
            begin
                if (dv_last)
                begin
                    cell_w_next = dv_quo_step;
                    dv_quo_next = CELL_W'(fh_reg);
                    dv_rem_next = '0;
                    dv_den_next = CELL_W'(gr_reg);
                    dv_cnt_next = '0;
                    state_next = ST_DIV_H;
                end
            end
            ST_DIV_H:
            begin
                if (dv_last)
                begin
                    cell_h_next = dv_quo_step;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cell_n_next = N_W'(product);
                // position is kept, so col and lx are found again from x
                dv_quo_next = CELL_W'(x_reg);
                dv_rem_next = '0;
                dv_den_next = cell_w_reg;
                dv_cnt_next = '0;
                state_next = ST_DIV_X;
            end
            ST_DIV_X:
            begin
                if (dv_last)
                begin
                    col_next = DIM_W'(dv_quo_step);
                    lx_next = dv_rem_step;
                    dv_quo_next = CELL_W'(y_reg);
                    dv_rem_next = '0;
                    dv_den_next = cell_h_reg;
                    dv_cnt_next = '0;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (dv_last)
                begin
                    row_next = DIM_W'(dv_quo_step);
                    ly_next = dv_rem_step;
                    ok_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  fw_next = cfg_data;
                CFG_FRAME_HEIGHT: fh_next = cfg_data;
                CFG_GRID_COLS:    gc_next = GRID_W'(cfg_data);
                CFG_GRID_ROWS:    gr_next = GRID_W'(cfg_data);
                default:          fw_next = fw_reg;
            endcase
            state_next = ST_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= CFG_W'(RESET_FRAME_WIDTH);
            fh_reg <= CFG_W'(RESET_FRAME_HEIGHT);
            gc_reg <= GRID_W'(RESET_GRID_COLS);
            gr_reg <= GRID_W'(RESET_GRID_ROWS);
            cell_w_reg <= CELL_W'(RESET_CELL_W);
            cell_h_reg <= CELL_W'(RESET_CELL_H);
            cell_n_reg <= N_W'(RESET_CELL_N);
            ok_reg <= 1'b1;
            state_reg <= ST_IDLE;
            x_reg <= '0;
            y_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            lx_reg <= '0;
            ly_reg <= '0;
        end
        else
        begin
            fw_reg <= fw_next;
            fh_reg <= fh_next;
            gc_reg <= gc_next;
            gr_reg <= gr_next;
            cell_w_reg <= cell_w_next;
            cell_h_reg <= cell_h_next;
            cell_n_reg <= cell_n_next;
            ok_reg <= ok_next;
            state_reg <= state_next;
            x_reg <= x_next;
            y_reg <= y_next;
            col_reg <= col_next;
            row_reg <= row_next;
            lx_reg <= lx_next;
            ly_reg <= ly_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_quo_reg <= dv_quo_next;
        dv_rem_reg <= dv_rem_next;
        dv_den_reg <= dv_den_next;
        dv_cnt_reg <= dv_cnt_next;
    end

endmodule

[src/caam_queue.sv]
module caam_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  caam_pkg::caam_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output caam_pkg::caam_item_t head,
    output logic                 empty
);

    import caam_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    caam_item_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head = slot_reg[rd_ptr_reg];

    always_comb
    begin
        do_push = push && !full;
        do_pop = pop && !empty;
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[src/caam_back.sv]
module caam_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  caam_pkg::caam_item_t       q_head,
    output logic                       q_pop,
    input  logic [caam_pkg::N_W-1:0]   cell_n,
    input  logic                       pop,
    output logic                       empty,
    output caam_pkg::caam_result_t     result
);

    import caam_pkg::*;

    localparam int AVG_STEPS = GRAY_W + 1;
    localparam int DQ_CNT_W = $clog2(AVG_STEPS + 1);
    localparam int DEN_W = N_W + GRAY_W;

    // accumulate stage
    logic             s2_valid_reg, s2_valid_next;
    caam_item_t       s2_item_reg;
    logic             s2_fwd_reg;
    logic [SUM_W-1:0] s2_fwd_sum_reg;
    logic             s2_hit_reg;
    logic [MAX_GRID_COLS-1:0] col_valid_reg, col_valid_next;

    logic [SUM_W-1:0] rd_sum, base_sum, new_sum;
    logic             s2_done, wr_en;

    // average divider
    logic                dq_busy_reg, dq_busy_next;
    logic [DQ_CNT_W-1:0] dq_cnt_reg, dq_cnt_next;
    logic [SUM_W-1:0]    dq_rem_reg, dq_rem_next;
    logic [DEN_W-1:0]    dq_den_reg, dq_den_next;
    logic [AVG_STEPS-1:0] dq_quo_reg, dq_quo_next;
    logic [COL_W-1:0]    dq_col_reg;
    logic [ROW_W-1:0]    dq_row_reg;
    logic                dq_re_reg;
    logic                dq_done, dq_ge, div_ready, div_start, out_load;
    logic [GRAY_W-1:0]   avg;

    logic         out_valid_reg, out_valid_next;
    caam_result_t out_reg;

    caam_ram #(
        .WIDTH(SUM_W),
        .DEPTH(MAX_GRID_COLS)
    ) u_sums (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(s2_item_reg.col),
        .wr_data(new_sum),
        .rd_en  (q_pop),
        .rd_addr(q_head.col),
        .rd_data(rd_sum)
    );

    assign empty = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        dq_done = (dq_cnt_reg == DQ_CNT_W'(AVG_STEPS));
        out_load = dq_busy_reg && dq_done && (!out_valid_reg || pop);
        div_ready = !dq_busy_reg || out_load;

        s2_done = s2_valid_reg && (!s2_item_reg.last || div_ready);
        wr_en = s2_done;
        div_start = s2_done && s2_item_reg.last;
        q_pop = !q_empty && (!s2_valid_reg || s2_done);

        // the write of the pop cycle is not yet in the read data
        if (s2_item_reg.first)
        begin
            base_sum = '0;
        end
        else if (s2_fwd_reg)
        begin
            base_sum = s2_fwd_sum_reg;
        end
        else if (s2_hit_reg)
        begin
            base_sum = rd_sum;
        end
        else
        begin
            base_sum = '0;
        end
        new_sum = base_sum + SUM_W'(s2_item_reg.gray);

        s2_valid_next = q_pop ? 1'b1 : (s2_done ? 1'b0 : s2_valid_reg);
        col_valid_next = col_valid_reg;
        if (wr_en)
        begin
            col_valid_next[s2_item_reg.col] = 1'b1;
        end
    end

    always_comb
    begin
        dq_ge = ({{(DEN_W-SUM_W){1'b0}}, dq_rem_reg} >= dq_den_reg);
        dq_busy_next = dq_busy_reg;
        dq_cnt_next = dq_cnt_reg;
        dq_rem_next = dq_rem_reg;
        dq_den_next = dq_den_reg;
        dq_quo_next = dq_quo_reg;

        if (dq_busy_reg && !dq_done)
        begin
            if (dq_ge)
            begin
                dq_rem_next = SUM_W'({{(DEN_W-SUM_W){1'b0}}, dq_rem_reg} - dq_den_reg);
            end
            dq_quo_next = {dq_quo_reg[AVG_STEPS-2:0], dq_ge};
            dq_den_next = dq_den_reg >> 1;
            dq_cnt_next = dq_cnt_reg + DQ_CNT_W'(1);
        end

        if (out_load)
        begin
            dq_busy_next = 1'b0;
        end
        if (div_start)
        begin
            dq_busy_next = 1'b1;
            dq_cnt_next = '0;
            dq_rem_next = new_sum;
            dq_den_next = {cell_n, {GRAY_W{1'b0}}};
            dq_quo_next = '0;
        end

        // top quotient bit set means the mean ran past 255
        avg = dq_quo_reg[AVG_STEPS-1] ? {GRAY_W{1'b1}} : dq_quo_reg[GRAY_W-1:0];

        out_valid_next = out_load ? 1'b1 : ((pop && out_valid_reg) ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            col_valid_reg <= '0;
            dq_busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            col_valid_reg <= col_valid_next;
            dq_busy_reg <= dq_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_item_reg <= q_head;
            s2_fwd_reg <= wr_en && (s2_item_reg.col == q_head.col);
            s2_fwd_sum_reg <= new_sum;
            s2_hit_reg <= col_valid_reg[q_head.col];
        end
        dq_cnt_reg <= dq_cnt_next;
        dq_rem_reg <= dq_rem_next;
        dq_den_reg <= dq_den_next;
        dq_quo_reg <= dq_quo_next;
        if (div_start)
        begin
            dq_col_reg <= s2_item_reg.col;
            dq_row_reg <= s2_item_reg.row;
            dq_re_reg <= s2_item_reg.row_end;
        end
        if (out_load)
        begin
            out_reg.cell_avg <= avg;
            out_reg.level <= caam_level(avg);
            out_reg.char_code <= caam_char(caam_level(avg));
            out_reg.cell_col <= dq_col_reg;
            out_reg.cell_row <= dq_row_reg;
            out_reg.row_end <= dq_re_reg;
        end
    end

endmodule

[src/cell_average_ascii_mapper_top.sv]
// cell average ascii mapper: gray pixels in raster order go in, one word per
// finished character cell comes out (mean gray, ramp level, ascii code,
// cell column and row, end-of-row flag).
// input queue side: a pixel word is taken when push is high and full is low.
// result queue side: the oldest result sits on the ports while empty is low
// and is taken when pop is high.
// configuration: cfg_we writes cfg_data into register cfg_index (0 frame
// width, 1 frame height, 2 grid columns, 3 grid rows). each write reruns the
// geometry setup with full held high: for a valid geometry, four serial
// divisions (cell width, cell height, then the current column and row).
// throughput: one pixel a cycle while full is low; a cell's last pixel
// occupies the serial mean divider, and a 4-word queue between front and
// back absorbs that before full rises.
// a stalled result queue stops the divider, then the accumulator, then the
// front queue fills and full goes high; nothing is dropped.
// reset: registers take 640x480 frame and 210x52 grid, position goes to the
// top-left, column sums read as zero; pixels are taken at once.
`include "cell_average_ascii_mapper_top_defines.svh"

module cell_average_ascii_mapper_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [caam_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [caam_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [caam_pkg::GRAY_W-1:0]    gray,
    input  logic                           frame_start,
    output logic                           empty,
    input  logic                           pop,
    output logic [6:0]                     char_code,
    output logic [3:0]                     level,
    output logic [caam_pkg::GRAY_W-1:0]    cell_avg,
    output logic [caam_pkg::COL_W-1:0]     cell_col,
    output logic [caam_pkg::ROW_W-1:0]     cell_row,
    output logic                           row_end
);

    import caam_pkg::*;

    logic             q_push, q_full, q_pop, q_empty;
    caam_item_t       q_in_item, q_head;
    logic [N_W-1:0]   cell_n;
    caam_result_t     result;

    caam_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .gray       (gray),
        .frame_start(frame_start),
        .full       (full),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_in_item),
        .cell_n     (cell_n)
    );

    caam_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_item(q_in_item),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    caam_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_empty(q_empty),
        .q_head (q_head),
        .q_pop  (q_pop),
        .cell_n (cell_n),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    assign char_code = result.char_code;
    assign level = result.level;
    assign cell_avg = result.cell_avg;
    assign cell_col = result.cell_col;
    assign cell_row = result.cell_row;
    assign row_end = result.row_end;

    `CAAM_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, full, "input open right after a register write")
    `CAAM_ASSERT_IMP(a_queue_no_overflow, q_full, !q_push, "push into a full front queue")
    `CAAM_ASSERT_IMP(a_level_matches_avg, !empty, level == caam_level(cell_avg), "level off mean")
    `CAAM_ASSERT_IMP(a_char_matches_level, !empty, char_code == caam_char(level), "char off level")

endmodule

[verif/tb_cell_average_ascii_mapper_top.sv]
`timescale 1ns / 100ps

module tb_cell_average_ascii_mapper_top;
    import caam_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PIXEL_TARGET = 1000;
    localparam logic [79:0] GLYPHS = " .:-=+*#%@";
    localparam logic [6:0] CHAR_SPACE = 7'd32;
    localparam logic [6:0] CHAR_AT = 7'd64;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic              fs;
        logic              typed;
        caam_result_t      word;
    } pixel_row_t;

    // 5x2 frame cut into two 2x2 cells, column 4 lies outside the grid
    localparam int N_DIRECTED = 26;
    localparam pixel_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // full-white frame, level clamps to 9
        '{8'd255, 1'b1, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b1, '{CHAR_AT, 4'd9, 8'd255, 8'd0, 8'd0, 1'b0}},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b1, '{CHAR_AT, 4'd9, 8'd255, 8'd1, 8'd0, 1'b1}},
        '{8'd255, 1'b0, 1'b0, '0},
        // black frame, cut short after the first cell
        '{8'd0, 1'b1, 1'b0, '0},
        '{8'd0, 1'b0, 1'b0, '0},
        '{8'd0, 1'b0, 1'b0, '0},
        '{8'd0, 1'b0, 1'b0, '0},
        '{8'd0, 1'b0, 1'b0, '0},
        '{8'd0, 1'b0, 1'b0, '0},
        '{8'd0, 1'b0, 1'b1, '{CHAR_SPACE, 4'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
        // frame interrupted after two pixels, stale sums must not leak
        '{8'd200, 1'b1, 1'b0, '0},
        '{8'd200, 1'b0, 1'b0, '0},
        '{8'd10, 1'b1, 1'b0, '0},
        '{8'd77, 1'b0, 1'b0, '0},
        '{8'd128, 1'b0, 1'b0, '0},
        '{8'd3, 1'b0, 1'b0, '0},
        '{8'd250, 1'b0, 1'b0, '0},
        '{8'd31, 1'b0, 1'b0, '0},
        '{8'd64, 1'b0, 1'b0, '0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 push;
    logic                 full;
    logic [GRAY_W-1:0]    gray;
    logic                 frame_start;
    logic                 empty;
    logic                 pop;
    logic [6:0]           char_code;
    logic [3:0]           level;
    logic [GRAY_W-1:0]    cell_avg;
    logic [COL_W-1:0]     cell_col;
    logic [ROW_W-1:0]     cell_row;
    logic                 row_end;

    // mirror of the block's geometry and accumulators
    logic [CFG_W-1:0]  frame_w;
    logic [CFG_W-1:0]  frame_h;
    logic [GRID_W-1:0] grid_c;
    logic [GRID_W-1:0] grid_r;
    int unsigned       cell_w_now;
    int unsigned       cell_h_now;
    logic [DIM_W-1:0]  pos_x;
    logic [DIM_W-1:0]  pos_y;
    logic [SUM_W-1:0]  column_acc [MAX_GRID_COLS];
    caam_result_t      expected_words [$];

    int unsigned pixels_sent = 0;
    int unsigned words_checked = 0;
    int unsigned settings_applied = 0;
    int unsigned mismatches = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    bit          hold_off_req = 1'b0;

    cell_average_ascii_mapper_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .gray(gray),
        .frame_start(frame_start),
        .empty(empty),
        .pop(pop),
        .char_code(char_code),
        .level(level),
        .cell_avg(cell_avg),
        .cell_col(cell_col),
        .cell_row(cell_row),
        .row_end(row_end)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void derive_geometry();
        if (grid_c >= 1 && grid_r >= 1 && grid_c <= MAX_GRID_COLS
            && grid_r <= GRID_ROWS_LIMIT && frame_w <= MAX_FRAME_DIM
            && frame_h <= MAX_FRAME_DIM && grid_c <= frame_w && grid_r <= frame_h)
        begin
            cell_w_now = frame_w / grid_c;
            cell_h_now = frame_h / grid_r;
        end
        else
        begin
            cell_w_now = 0;
            cell_h_now = 0;
        end
    endfunction

    function automatic bit predict_pixel(input logic [GRAY_W-1:0] g, input logic fs,
                                         output caam_result_t w);
        int unsigned x, y, col, row, lx, ly, avg, lvl;
        bit done;
        done = 1'b0;
        w = '0;
        if (fs)
        begin
            pos_x = '0;
            pos_y = '0;
        end
        x = pos_x;
        y = pos_y;
        if (cell_w_now != 0 && cell_h_now != 0 && x < cell_w_now * grid_c
            && y < cell_h_now * grid_r)
        begin
            col = x / cell_w_now;
            row = y / cell_h_now;
            lx = x - col * cell_w_now;
            ly = y - row * cell_h_now;
            // top-left pixel of a cell restarts its column sum
            if (lx == 0 && ly == 0)
                column_acc[col] = SUM_W'(g);
            else
                column_acc[col] = column_acc[col] + SUM_W'(g);
            if (lx == cell_w_now - 1 && ly == cell_h_now - 1)
            begin
                avg = column_acc[col] / (cell_w_now * cell_h_now);
                if (avg > 255)
                    avg = 255;
                lvl = avg * 10 / 255;
                if (lvl > 9)
                    lvl = 9;
                w.char_code = 7'(GLYPHS[8 * (9 - lvl) +: 8]);
                w.level = 4'(lvl);
                w.cell_avg = 8'(avg);
                w.cell_col = 8'(col);
                w.cell_row = 8'(row);
                w.row_end = (col + 1 == grid_c);
                done = 1'b1;
            end
        end
        x = x + 1;
        if (x >= frame_w || x >= MAX_FRAME_DIM)
        begin
            x = 0;
            y = y + 1;
            if (y >= frame_h || y >= MAX_FRAME_DIM)
                y = 0;
        end
        pos_x = DIM_W'(x);
        pos_y = DIM_W'(y);
        return done;
    endfunction

    // mostly no gap, some short ones, now and then a long one
    function automatic int unsigned pick_gap(input int unsigned idle_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (idle_pct == 0)
            return 0;
        if (r < 2)
            return $urandom_range(60, 20);
        if (r < idle_pct)
            return $urandom_range(3, 1);
        return 0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_word();
        caam_result_t want;
        if (expected_words.size() == 0)
        begin
            $error("result word with none expected: col %0d row %0d avg %0d",
                   cell_col, cell_row, cell_avg);
            mismatches++;
        end
        else
        begin
            want = expected_words.pop_front();
            check_field("char_code", want.char_code, char_code);
            check_field("level", want.level, level);
            check_field("cell_avg", want.cell_avg, cell_avg);
            check_field("cell_col", want.cell_col, cell_col);
            check_field("cell_row", want.cell_row, cell_row);
            check_field("row_end", want.row_end, row_end);
        end
        words_checked++;
    endfunction

    task automatic send_pixel(input logic [GRAY_W-1:0] g, input logic fs, input logic typed,
                              input caam_result_t typed_word);
        caam_result_t w;
        int unsigned gap;
        push <= 1'b1;
        gray <= g;
        frame_start <= fs;
        do
            @(posedge clk);
        while (full);
        if (predict_pixel(g, fs, w) && !typed)
            expected_words.push_back(w);
        if (typed)
            expected_words.push_back(typed_word);
        pixels_sent++;
        gap = pick_gap(src_idle_pct);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  frame_w = CFG_W'(value);
            CFG_FRAME_HEIGHT: frame_h = CFG_W'(value);
            CFG_GRID_COLS:    grid_c = GRID_W'(value);
            CFG_GRID_ROWS:    grid_r = GRID_W'(value);
            default:          ;
        endcase
        derive_geometry();
        // geometry setup holds the block busy for a while after each write
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_geometry(input int unsigned fw, input int unsigned fh,
                                  input int unsigned gc, input int unsigned gr);
        while (expected_words.size() != 0)
            @(posedge clk);
        // pixels with no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
        write_reg(CFG_GRID_COLS, gc);
        write_reg(CFG_GRID_ROWS, gr);
        settings_applied++;
        src_idle_pct = 20 * $urandom_range(2);
        sink_idle_pct = 20 * $urandom_range(2);
    endtask

    // raster frames; the noisy form drops or adds frame marks at random
    task automatic stream_frames(input int unsigned n_items, input bit clean);
        caam_result_t none;
        int unsigned sent, frame_len, i, mode;
        logic [GRAY_W-1:0] base, g;
        logic fs;
        none = '0;
        sent = 0;
        while (sent < n_items)
        begin
            frame_len = frame_w * frame_h;
            if (frame_len == 0)
                frame_len = 1;
            mode = clean ? 0 : $urandom_range(2);
            base = $urandom;
            for (i = 0; i < frame_len && sent < n_items; i++)
            begin
                if (clean)
                    fs = (i == 0);
                else if (i == 0)
                    fs = ($urandom_range(7) != 0);
                else
                    fs = ($urandom_range(79) == 0);
                case (mode)
                    0:       g = $urandom;
                    1:       g = base;
                    default: g = $urandom_range(1) ? 8'hFF : 8'h00;
                endcase
                send_pixel(g, fs, 1'b0, none);
                sent++;
            end
        end
        push <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned fw, input int unsigned fh,
                             input int unsigned gc, input int unsigned gr,
                             input int unsigned n_items, input bit clean);
        apply_geometry(fw, fh, gc, gr);
        stream_frames(n_items, clean);
    endtask

    task automatic random_phase();
        int unsigned fw, fh, gc, gr;
        fw = $urandom_range(24, 1);
        fh = $urandom_range(10, 1);
        gc = $urandom_range((fw < 8) ? fw : 8, 1);
        gr = $urandom_range((fh < 4) ? fh : 4, 1);
        if ($urandom_range(7) == 0)
            gc = fw + $urandom_range(3, 1);
        run_phase(fw, fh, gc, gr, $urandom_range(70, 30), 1'b0);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data <= '0;
        push <= 1'b0;
        gray <= '0;
        frame_start <= 1'b0;
        frame_w = RESET_FRAME_WIDTH;
        frame_h = RESET_FRAME_HEIGHT;
        grid_c = RESET_GRID_COLS;
        grid_r = RESET_GRID_ROWS;
        derive_geometry();
        pos_x = '0;
        pos_y = '0;
        foreach (column_acc[i])
            column_acc[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry, taken straight away
        stream_frames(20, 1'b0);

        apply_geometry(5, 2, 2, 1);
        for (int i = 0; i < N_DIRECTED; i++)
            send_pixel(DIRECTED_ROWS[i].gray, DIRECTED_ROWS[i].fs, DIRECTED_ROWS[i].typed,
                       DIRECTED_ROWS[i].word);
        push <= 1'b0;

        // each run_phase here disables the grid; position keeps moving
        random_phase();
        run_phase(3, 1, 4, 1, 12, 1'b0);
        run_phase(1, 2, 1, 3, 12, 1'b0);
        random_phase();
        run_phase(7, 5, 0, 2, 12, 1'b0);
        run_phase(7, 5, 2, 0, 12, 1'b0);
        random_phase();
        // grid_cols keeps 9 bits of the write: 511 columns
        run_phase(600, 1, 8191, 1, 12, 1'b0);
        run_phase(1, 300, 1, 257, 12, 1'b0);
        run_phase(4097, 1, 256, 1, 40, 1'b0);
        run_phase(1, 4097, 1, 256, 40, 1'b0);
        random_phase();

        // 1x1 cells: every pixel is a word, out to column and row 255, result side held off; then 4096-wide frames
        apply_geometry(256, 1, 256, 1);
        hold_off_req = 1'b1;
        stream_frames(256, 1'b1);
        run_phase(1, 256, 1, 256, 256, 1'b1);
        run_phase(4096, 1, 256, 1, 40, 1'b0);
        run_phase(4096, 4096, 1, 1, 10, 1'b0);

        while (pixels_sent < PIXEL_TARGET)
            random_phase();

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d pixel words in, %0d result words checked, %0d grid settings",
                 pixels_sent, words_checked, settings_applied);
        $display("incl. disabled grids, 1x1 cells to column/row 255, broken frames, stalls");
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // result side: random pop gaps plus one long hold-off on request
    initial
    begin
        int unsigned hold;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_word();
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold = HOLD_OFF_CYCLES;
            end
            else
            begin
                hold = pick_gap(sink_idle_pct);
            end
            if (hold != 0)
            begin
                pop <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d result words outstanding", expected_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[cell_average_ascii_mapper_top.f]
+incdir+src
src/caam_pkg.sv
src/caam_ram.sv
src/caam_front.sv
src/caam_queue.sv
src/caam_back.sv
src/cell_average_ascii_mapper_top.sv
verif/tb_cell_average_ascii_mapper_top.sv
